@@ hdl/spd_pkg.sv @@
package spd_pkg;

    localparam int MAX_LEN = 64;
    localparam int LEN_W = 7;

    localparam logic [7:0] START_MARK = 8'h24;
    localparam logic [7:0] END_MARK = 8'h0A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB = 8'h09;
    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_PLUS = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;
    localparam logic [7:0] CHAR_NUL = 8'h00;

    localparam logic [7:0] INIT_WORD [0:3] = '{8'h69, 8'h6E, 8'h69, 8'h74};
    localparam logic [7:0] OK_WORD [0:1] = '{8'h6F, 8'h6B};
    localparam logic [LEN_W-1:0] INIT_LEN = LEN_W'(4);
    localparam logic [LEN_W-1:0] OK_LEN = LEN_W'(2);

    typedef enum logic [1:0] {
        EV_OK_REPLY = 2'd0,
        EV_LINK_UP  = 2'd1,
        EV_DATA     = 2'd2
    } event_kind_t;

    typedef enum logic [1:0] {
        PH_SKIP   = 2'd0,
        PH_SIGN   = 2'd1,
        PH_DIGITS = 2'd2,
        PH_DONE   = 2'd3
    } phase_t;

    typedef struct packed {
        logic              in_packet;
        logic [LEN_W-1:0]  content_length;
        logic              host_preparing;
        logic              link_up;
        logic              string_ended;
        logic              match_init;
        logic              match_ok;
        phase_t            number_phase;
        logic              number_negative;
        logic              digits_seen;
        logic [15:0]       accumulator;
    } spd_state_t;

    typedef struct packed {
        logic               emit;
        event_kind_t        event_kind;
        logic signed [15:0] doubled_value;
        logic               number_found;
    } spd_result_t;

    localparam spd_state_t STATE_RESET = '{
        in_packet:       1'b0,
        content_length:  '0,
        host_preparing:  1'b0,
        link_up:         1'b0,
        string_ended:    1'b0,
        match_init:      1'b1,
        match_ok:        1'b1,
        number_phase:    PH_SKIP,
        number_negative: 1'b0,
        digits_seen:     1'b0,
        accumulator:     16'd0
    };

    function automatic spd_state_t clear_content(spd_state_t s);
        spd_state_t r;
        r = s;
        r.content_length = '0;
        r.string_ended = 1'b0;
        r.match_init = 1'b1;
        r.match_ok = 1'b1;
        r.number_phase = PH_SKIP;
        r.number_negative = 1'b0;
        r.digits_seen = 1'b0;
        r.accumulator = 16'd0;
        return r;
    endfunction

endpackage

@@ hdl/spd_input_stage.sv @@
module spd_input_stage (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    input  logic       down_free,
    output logic       take,
    output logic [7:0] byte_q
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    assign take = valid_reg && down_free;
    assign in_ready = !valid_reg || take;
    assign byte_q = byte_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= rx_byte;
        end
    end

endmodule

@@ hdl/spd_parser.sv @@
module spd_parser (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 take,
    input  logic [7:0]           byte_q,
    output spd_pkg::spd_result_t result
);

    spd_pkg::spd_state_t state_reg;
    spd_pkg::spd_state_t state_next;

    spd_pkg::spd_state_t cur;
    logic [spd_pkg::LEN_W-1:0] pos;
    logic is_space;
    logic is_digit;
    logic [15:0] digit_val;
    logic [15:0] acc_base;
    logic is_init;
    logic is_ok;
    logic [15:0] value;

    assign is_space = (byte_q == spd_pkg::CHAR_SPACE)
        || (byte_q >= spd_pkg::CHAR_TAB && byte_q <= spd_pkg::CHAR_CR);
    assign is_digit = (byte_q >= spd_pkg::CHAR_ZERO) && (byte_q <= spd_pkg::CHAR_NINE);
    assign digit_val = {12'd0, byte_q[3:0]};

    always_comb
    begin
        cur = state_reg;
        if (state_reg.content_length >= spd_pkg::LEN_W'(spd_pkg::MAX_LEN))
        begin
            cur = spd_pkg::clear_content(state_reg);
        end
        pos = cur.content_length;
        state_next = cur;
        result = '{emit: 1'b0, event_kind: spd_pkg::EV_OK_REPLY,
                   doubled_value: 16'sd0, number_found: 1'b0};
        acc_base = (cur.number_phase == spd_pkg::PH_DIGITS) ? cur.accumulator : 16'd0;
        is_init = cur.match_init && (cur.string_ended || pos == spd_pkg::INIT_LEN);
        is_ok = cur.match_ok && (cur.string_ended || pos == spd_pkg::OK_LEN);
        value = 16'd0;
        if (cur.digits_seen)
        begin
            value = cur.number_negative ? 16'(-cur.accumulator) : cur.accumulator;
        end

        if (byte_q == spd_pkg::START_MARK)
        begin
            state_next = spd_pkg::clear_content(cur);
            state_next.in_packet = 1'b1;
        end
        else if (!cur.in_packet)
        begin
            state_next = cur;
        end
        else if (byte_q != spd_pkg::END_MARK)
        begin
            state_next.content_length = pos + 1'b1;
            if (!cur.string_ended)
            begin
                if (byte_q == spd_pkg::CHAR_NUL)
                begin
                    state_next.string_ended = 1'b1;
                    state_next.match_init = cur.match_init && (pos == spd_pkg::INIT_LEN);
                    state_next.match_ok = cur.match_ok && (pos == spd_pkg::OK_LEN);
                end
                else
                begin
                    state_next.match_init = cur.match_init && (pos < spd_pkg::INIT_LEN)
                        && (byte_q == spd_pkg::INIT_WORD[pos[1:0]]);
                    state_next.match_ok = cur.match_ok && (pos < spd_pkg::OK_LEN)
                        && (byte_q == spd_pkg::OK_WORD[pos[0]]);
                    unique case (cur.number_phase)
                        spd_pkg::PH_SKIP:
                        begin
                            if (is_space)
                            begin
                                state_next.number_phase = spd_pkg::PH_SKIP;
                            end
                            else if (byte_q == spd_pkg::CHAR_PLUS
                                     || byte_q == spd_pkg::CHAR_MINUS)
                            begin
                                state_next.number_negative = (byte_q == spd_pkg::CHAR_MINUS);
                                state_next.number_phase = spd_pkg::PH_SIGN;
                            end
                            else if (is_digit)
                            begin
                                state_next.accumulator = digit_val;
                                state_next.digits_seen = 1'b1;
                                state_next.number_phase = spd_pkg::PH_DIGITS;
                            end
                            else
                            begin
                                state_next.number_phase = spd_pkg::PH_DONE;
                            end
                        end
                        spd_pkg::PH_SIGN, spd_pkg::PH_DIGITS:
                        begin
                            if (is_digit)
                            begin
                                state_next.accumulator = (acc_base << 3) + (acc_base << 1)
                                    + digit_val;
                                state_next.digits_seen = 1'b1;
                                state_next.number_phase = spd_pkg::PH_DIGITS;
                            end
                            else
                            begin
                                state_next.number_phase = spd_pkg::PH_DONE;
                            end
                        end
                        spd_pkg::PH_DONE:
                        begin
                            state_next.number_phase = spd_pkg::PH_DONE;
                        end
                    endcase
                end
            end
        end
        else
        begin
            state_next = spd_pkg::clear_content(cur);
            state_next.in_packet = 1'b0;
            if (!cur.link_up)
            begin
                if (is_init)
                begin
                    state_next.host_preparing = 1'b1;
                    result.emit = 1'b1;
                    result.event_kind = spd_pkg::EV_OK_REPLY;
                end
                else if (cur.host_preparing && is_ok)
                begin
                    state_next.link_up = 1'b1;
                    result.emit = 1'b1;
                    result.event_kind = spd_pkg::EV_LINK_UP;
                end
            end
            else
            begin
                result.emit = 1'b1;
                result.event_kind = spd_pkg::EV_DATA;
                result.doubled_value = {value[14:0], 1'b0};
                result.number_found = cur.digits_seen;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= spd_pkg::STATE_RESET;
        end
        else if (take)
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ hdl/spd_output_stage.sv @@
module spd_output_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 take,
    input  spd_pkg::spd_result_t result,
    output logic                 down_free,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [1:0]           event_kind,
    output logic signed [15:0]   doubled_value,
    output logic                 number_found
);

    logic                  valid_reg;
    logic                  valid_next;
    spd_pkg::event_kind_t  kind_reg;
    logic signed [15:0]    value_reg;
    logic                  found_reg;

    assign down_free = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign event_kind = kind_reg;
    assign doubled_value = value_reg;
    assign number_found = found_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (take && result.emit)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && result.emit)
        begin
            kind_reg <= result.event_kind;
            value_reg <= result.doubled_value;
            found_reg <= result.number_found;
        end
    end

endmodule

@@ hdl/serial_packet_handshake_deframer_core.sv @@
// Serial packet deframer: one received byte per input word, packets run from '$' to
// line feed, content wraps after MAX_LEN bytes. Before the link is up a packet "init"
// yields an ok-reply event and a following "ok" yields a link-up event; after that
// every packet yields a data event with twice its decimal value (16-bit wrap) and a
// flag telling whether any digit was found. A byte is taken every cycle unless in_ready
// is low; each word passes an input register and the parser state update; an event is
// written to the output register with its packet's last byte and held there while
// out_ready is low. A stalled output stops intake only once that register is full.
module serial_packet_handshake_deframer_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         rx_byte,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         event_kind,
    output logic signed [15:0] doubled_value,
    output logic               number_found
);

    logic                 down_free;
    logic                 take;
    logic [7:0]           byte_q;
    spd_pkg::spd_result_t result;

    spd_input_stage u_in (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .rx_byte   (rx_byte),
        .down_free (down_free),
        .take      (take),
        .byte_q    (byte_q)
    );

    spd_parser u_parse (
        .clk    (clk),
        .rst_n  (rst_n),
        .take   (take),
        .byte_q (byte_q),
        .result (result)
    );

    spd_output_stage u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .take          (take),
        .result        (result),
        .down_free     (down_free),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .event_kind    (event_kind),
        .doubled_value (doubled_value),
        .number_found  (number_found)
    );

endmodule

@@ hdl/spd_checker.sv @@
module spd_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic [1:0]         event_kind,
    input logic signed [15:0] doubled_value,
    input logic               number_found
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(event_kind)
            && $stable(doubled_value) && $stable(number_found))
        else $error("stalled output word changed");

    // handshake events carry no number
    a_ctrl_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_kind != spd_pkg::EV_DATA |-> doubled_value == 16'sd0
            && !number_found)
        else $error("control event carries a value");

    // no digits gives zero
    a_no_number: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !number_found |-> doubled_value == 16'sd0)
        else $error("value without number");

    // doubled value is even and kind is known
    a_even: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !doubled_value[0] && (event_kind == spd_pkg::EV_OK_REPLY
            || event_kind == spd_pkg::EV_LINK_UP || event_kind == spd_pkg::EV_DATA))
        else $error("odd value or bad event kind");

    // input stalls only behind a stalled result word
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled with free output");

endmodule

bind serial_packet_handshake_deframer_core spd_checker u_spd_checker (.*);

@@ sim/tb.sv @@
module tb;

    typedef struct packed {
        spd_pkg::event_kind_t kind;
        logic signed [15:0]   dval;
        logic                 found;
    } parsed_event_t;

    localparam logic [31:0] INIT_TEXT = "init";
    localparam logic [15:0] OK_TEXT = "ok";
    localparam logic [7:0] CHAR_VT = 8'h0B;
    localparam logic [7:0] CHAR_FF = 8'h0C;
    localparam int BYTE_TARGET = 750;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [7:0]         rx_byte;
    logic               out_valid;
    logic               out_ready;
    logic [1:0]         event_kind;
    logic signed [15:0] doubled_value;
    logic               number_found;

    // parser state as seen from the byte stream
    logic                        in_pkt_m;
    logic [spd_pkg::LEN_W-1:0]   len_m;
    logic                        prep_m;
    logic                        link_m;
    logic                        ended_m;
    logic                        init_m;
    logic                        ok_m;
    spd_pkg::phase_t             phase_m;
    logic                        neg_m;
    logic                        digits_m;
    logic [15:0]                 acc_m;

    parsed_event_t      expected_events[$];
    logic [7:0]         pkt_q[$];

    int  errors = 0;
    int  bytes_used = 0;
    int  bytes_fed = 0;
    int  stall_cycles = 0;
    int  hold_left = 0;
    int  kind_count[3] = '{0, 0, 0};
    bit  idle_on = 1'b1;

    serial_packet_handshake_deframer_core dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .rx_byte(rx_byte),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .event_kind(event_kind),
        .doubled_value(doubled_value),
        .number_found(number_found)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #3600000;
        $display("tb: done, errors");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= 40)
            $display("tb: mismatch at %0t: %s", $realtime, msg);
    endtask

    task automatic wipe_content();
        len_m = '0;
        ended_m = 1'b0;
        init_m = 1'b1;
        ok_m = 1'b1;
        phase_m = spd_pkg::PH_SKIP;
        neg_m = 1'b0;
        digits_m = 1'b0;
        acc_m = 16'd0;
    endtask

    task automatic predict_byte(input logic [7:0] c);
        parsed_event_t ev;
        logic [15:0] v;
        bit is_ws;
        bit is_digit;
        int pos;
        if (len_m >= spd_pkg::MAX_LEN)
            wipe_content();
        if (c == spd_pkg::START_MARK)
        begin
            wipe_content();
            in_pkt_m = 1'b1;
            bytes_used++;
            return;
        end
        if (!in_pkt_m)
            return;
        bytes_used++;
        pos = len_m;
        if (c != spd_pkg::END_MARK)
        begin
            if (!ended_m)
            begin
                if (c == spd_pkg::CHAR_NUL)
                begin
                    ended_m = 1'b1;
                    if (len_m != spd_pkg::INIT_LEN) init_m = 1'b0;
                    if (len_m != spd_pkg::OK_LEN) ok_m = 1'b0;
                end
                else
                begin
                    if (pos >= 4 || c != INIT_TEXT[8*(3-(pos%4)) +: 8]) init_m = 1'b0;
                    if (pos >= 2 || c != OK_TEXT[8*(1-(pos%2)) +: 8]) ok_m = 1'b0;
                    is_ws = (c == spd_pkg::CHAR_SPACE)
                        || (c >= spd_pkg::CHAR_TAB && c <= spd_pkg::CHAR_CR);
                    is_digit = (c >= spd_pkg::CHAR_ZERO && c <= spd_pkg::CHAR_NINE);
                    if (phase_m != spd_pkg::PH_DONE)
                    begin
                        if (is_digit)
                        begin
                            acc_m = 16'(((phase_m == spd_pkg::PH_DIGITS) ? acc_m : 16'd0)
                                        * 10 + (c - spd_pkg::CHAR_ZERO));
                            digits_m = 1'b1;
                            phase_m = spd_pkg::PH_DIGITS;
                        end
                        else if (phase_m == spd_pkg::PH_SKIP && is_ws)
                        begin
                        end
                        else if (phase_m == spd_pkg::PH_SKIP
                                 && (c == spd_pkg::CHAR_PLUS || c == spd_pkg::CHAR_MINUS))
                        begin
                            neg_m = (c == spd_pkg::CHAR_MINUS);
                            phase_m = spd_pkg::PH_SIGN;
                        end
                        else
                            phase_m = spd_pkg::PH_DONE;
                    end
                end
            end
            len_m = len_m + 1'b1;
            return;
        end
        // end of packet
        if (!ended_m)
        begin
            if (len_m != spd_pkg::INIT_LEN) init_m = 1'b0;
            if (len_m != spd_pkg::OK_LEN) ok_m = 1'b0;
        end
        if (!link_m)
        begin
            if (init_m)
            begin
                prep_m = 1'b1;
                ev = '{kind: spd_pkg::EV_OK_REPLY, dval: 16'sd0, found: 1'b0};
                expected_events.push_back(ev);
            end
            else if (prep_m && ok_m)
            begin
                link_m = 1'b1;
                ev = '{kind: spd_pkg::EV_LINK_UP, dval: 16'sd0, found: 1'b0};
                expected_events.push_back(ev);
            end
        end
        else
        begin
            v = 16'd0;
            if (digits_m)
                v = neg_m ? 16'(-acc_m) : acc_m;
            ev.kind = spd_pkg::EV_DATA;
            ev.dval = {v[14:0], 1'b0};
            ev.found = digits_m;
            expected_events.push_back(ev);
        end
        in_pkt_m = 1'b0;
        wipe_content();
    endtask

    // one word on the input channel; called just after a rising edge
    task automatic send_byte(input logic [7:0] b);
        @(negedge clk);
        while (idle_on && $urandom_range(99) < 19)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        bytes_fed++;
        predict_byte(b);
    endtask

    task automatic send_packet();
        while (pkt_q.size() != 0)
            send_byte(pkt_q.pop_front());
    endtask

    task automatic push_str(input string s);
        for (int i = 0; i < s.len(); i++)
            pkt_q.push_back(s[i]);
    endtask

    // any byte that neither opens nor closes a packet
    task automatic push_body(input int n);
        logic [7:0] b;
        repeat (n)
        begin
            b = $urandom_range(255);
            while (b == spd_pkg::START_MARK || b == spd_pkg::END_MARK)
                b = $urandom_range(255);
            pkt_q.push_back(b);
        end
    endtask

    task automatic push_spacing();
        repeat ($urandom_range(2))
        begin
            case ($urandom_range(4))
                0: pkt_q.push_back(spd_pkg::CHAR_SPACE);
                1: pkt_q.push_back(spd_pkg::CHAR_TAB);
                2: pkt_q.push_back(CHAR_VT);
                3: pkt_q.push_back(CHAR_FF);
                default: pkt_q.push_back(spd_pkg::CHAR_CR);
            endcase
        end
    endtask

    task automatic push_sign();
        case ($urandom_range(2))
            1: pkt_q.push_back(spd_pkg::CHAR_PLUS);
            2: pkt_q.push_back(spd_pkg::CHAR_MINUS);
            default: ;
        endcase
    endtask

    task automatic push_number(input bit extreme);
        int v;
        push_spacing();
        push_sign();
        if (extreme)
        begin
            case ($urandom_range(6))
                0: v = 0;
                1: v = 32767;
                2: v = 32768;
                3: v = 65535;
                4: v = 65536;
                5: v = 16384;
                default: v = 99999;
            endcase
            push_str($sformatf("%0d", v));
        end
        else
        begin
            repeat ($urandom_range(1, 6))
                pkt_q.push_back(spd_pkg::CHAR_ZERO + 8'($urandom_range(9)));
        end
        v = $urandom_range(99);
        if (v < 25)
            push_body($urandom_range(1, 3));
        else if (v < 40)
        begin
            pkt_q.push_back(spd_pkg::CHAR_NUL);
            push_body($urandom_range(3));
        end
    endtask

    task automatic test_directed_handshake();
        send_byte(8'hFF);
        push_str("$ok\n");
        push_str("$in$init");
        pkt_q.push_back(spd_pkg::CHAR_NUL);
        push_str("q\n");
        push_str("$ok\n");
        send_packet();
    endtask

    task automatic test_directed_values();
        push_str("$-\n");
        pkt_q.push_back(spd_pkg::START_MARK);
        pkt_q.push_back(8'hFF);
        pkt_q.push_back(spd_pkg::END_MARK);
        push_str("$-32768\n");
        send_packet();
    endtask

    task automatic test_random_traffic(input int target, input bit with_idle);
        int pick;
        idle_on = with_idle;
        while (bytes_used < target)
        begin
            pick = $urandom_range(99);
            if (pick < 86)
                pkt_q.push_back(spd_pkg::START_MARK);
            if (pick < 55)
                push_number(1'b0);
            else if (pick < 65)
                push_number(1'b1);
            else if (pick < 72)
            begin
                push_spacing();
                push_sign();
            end
            else if (pick < 80)
                push_body($urandom_range(8));
            else if (pick < 86)
            begin
                // packet restarted partway through
                push_body($urandom_range(5));
                pkt_q.push_back(spd_pkg::START_MARK);
                push_number($urandom_range(1));
            end
            else if (pick < 91)
            begin
                // packet that never ends
                pkt_q.push_back(spd_pkg::START_MARK);
                push_body($urandom_range(1, 6));
            end
            else if (pick < 95)
                push_body($urandom_range(1, 4));
            else
            begin
                // content overflow, only the tail after the wrap counts
                pkt_q.push_back(spd_pkg::START_MARK);
                push_body(spd_pkg::MAX_LEN);
                if ($urandom_range(1))
                    pkt_q[1 + $urandom_range(3)] = spd_pkg::CHAR_NUL;
                if ($urandom_range(3) != 0)
                    push_number($urandom_range(1));
                pkt_q.push_back(spd_pkg::END_MARK);
            end
            if (pick < 86)
                pkt_q.push_back(spd_pkg::END_MARK);
            send_packet();
        end
    endtask

    task automatic test_backpressure();
        idle_on = 1'b0;
        hold_left = 250;
        repeat (25)
        begin
            push_str($sformatf("$%0d\n", $urandom_range(999)));
            send_packet();
        end
    endtask

    initial
    begin : drain_events
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left = hold_left - 1;
            end
            else
                out_ready <= !(idle_on && $urandom_range(99) < 19);
        end
    end

    always @(posedge clk)
    begin : check_events
        parsed_event_t want;
        if (in_valid && !in_ready)
            stall_cycles++;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_events.size() == 0)
                report_mismatch($sformatf("unexpected event kind %0d value %0d",
                                          event_kind, doubled_value));
            else
            begin
                want = expected_events.pop_front();
                if (want.kind <= spd_pkg::EV_DATA)
                    kind_count[want.kind]++;
                if (event_kind !== want.kind)
                    report_mismatch($sformatf("event_kind %0d, wanted %0d",
                                              event_kind, want.kind));
                if (doubled_value !== want.dval)
                    report_mismatch($sformatf("doubled_value %0d, wanted %0d",
                                              doubled_value, want.dval));
                if (number_found !== want.found)
                    report_mismatch($sformatf("number_found %0b, wanted %0b",
                                              number_found, want.found));
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        rx_byte = 8'h00;
        in_pkt_m = 1'b0;
        prep_m = 1'b0;
        link_m = 1'b0;
        wipe_content();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_handshake();
        test_directed_values();
        test_random_traffic(400, 1'b1);
        test_backpressure();
        test_random_traffic(560, 1'b0);
        test_random_traffic(BYTE_TARGET, 1'b1);

        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_events.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (expected_events.size() != 0)
            report_mismatch("events still outstanding");

        $display("tb: %0d bytes fed (%0d inside packets), %0d input stall cycles",
                 bytes_fed, bytes_used, stall_cycles);
        $display("tb: events checked: %0d ok replies, %0d link ups, %0d values",
                 kind_count[0], kind_count[1], kind_count[2]);
        if (errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/spd_pkg.sv
hdl/spd_input_stage.sv
hdl/spd_parser.sv
hdl/spd_output_stage.sv
hdl/serial_packet_handshake_deframer_core.sv
hdl/spd_checker.sv
sim/tb.sv
